### src/ism_pkg.sv
// Package for the interval set merge/query block.
// Holds widths, request codes and controller command/status types.
`timescale 1ns / 1ps
`default_nettype none
package ism_pkg;
	localparam int MaxRanges = 64;
	localparam int RevWidth = 32;
	localparam int IdxWidth = $clog2(MaxRanges);
	localparam int CntWidth = $clog2(MaxRanges + 1);
	localparam logic [RevWidth-1:0] RevMax = {RevWidth{1'b1}};

	typedef enum logic [1:0] {
		REQ_ADD  = 2'd0,
		REQ_NEXT = 2'd1,
		REQ_PREV = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef struct packed {
		logic load;      // capture request, clear accumulators
		logic scan;      // examine entry at scan index
		logic scan_rst;  // restart index for second pass
		logic write;     // write compacted entry
		logic place;     // write merged range at write index
		logic commit;    // take new count
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic is_add;
		logic empty_add;
		logic full_drop;
		logic need_place;  // merged range not yet written and belongs here
		logic cur_keep;    // current entry survives
	} sts_t;
endpackage
`default_nettype wire

### src/ism_if.sv
// Valid/ready channel interface carrying a payload type.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface ism_if #(parameter type payload_t = logic) (input wire logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### src/ism_dp.sv
// Datapath: range table memories, scan and compaction into a shadow bank.
// Depends on ism_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ism_dp (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ism_pkg::cmd_t cmd,
	output ism_pkg::sts_t sts,
	input  wire logic [1:0] in_req,
	input  wire logic [ism_pkg::RevWidth-1:0] in_rev,
	input  wire logic [ism_pkg::RevWidth-1:0] in_span,
	output logic [ism_pkg::RevWidth-1:0] res_ans,
	output logic res_found,
	output logic res_drop
);
	localparam int W = ism_pkg::RevWidth;
	localparam int N = ism_pkg::MaxRanges;
	localparam int IW = ism_pkg::IdxWidth;
	localparam int CW = ism_pkg::CntWidth;

	// two banks; compaction writes the inactive bank, then it becomes active
	logic [W-1:0] st_mem0 [N];
	logic [W-1:0] en_mem0 [N];
	logic [W-1:0] st_mem1 [N];
	logic [W-1:0] en_mem1 [N];
	logic bank_q;
	logic [CW-1:0] count_q, idx_q, wr_q;
	logic [1:0] req_q;
	logic [W-1:0] s_q, e_q, ms_q, me_q, rev_q, ans_q;
	logic merged_q, found_q, placed_q, empty_q;
	logic [W-1:0] a_s1, b_s1;

	// entry ends are stored, not lengths; an end never exceeds RevMax
	// hold the read data while the merged range is placed ahead of it
	always_ff @(posedge clk) begin
		if (!cmd.place) begin
			if (bank_q) begin
				a_s1 <= st_mem1[idx_q[IW-1:0]];
				b_s1 <= en_mem1[idx_q[IW-1:0]];
			end else begin
				a_s1 <= st_mem0[idx_q[IW-1:0]];
				b_s1 <= en_mem0[idx_q[IW-1:0]];
			end
		end
	end

	logic [W:0] sum;
	logic [W-1:0] e_new;
	logic touch, hit_rev;
	assign sum = {1'b0, in_rev} + {1'b0, in_span};
	assign e_new = (sum > {1'b0, ism_pkg::RevMax}) ? ism_pkg::RevMax : sum[W-1:0];
	assign touch = (a_s1 <= e_q) && (b_s1 >= s_q);
	assign hit_rev = (a_s1 <= rev_q) && (rev_q < b_s1);

	// the read-data register captures the entry addressed by the index counter
	logic valid_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd.place) begin
			valid_s1 <= cmd.scan && (idx_q < count_q);
		end
	end

	assign sts.scan_done = !valid_s1 && (idx_q >= count_q) && !cmd.load;
	assign sts.is_add = (req_q == ism_pkg::REQ_ADD);
	assign sts.empty_add = empty_q;
	assign sts.full_drop = !merged_q && (count_q == CW'(N));
	assign sts.cur_keep = valid_s1 && !touch;
	assign sts.need_place = !placed_q && (valid_s1 ? (a_s1 > me_q) : (idx_q >= count_q));

	logic wr_en, wr_merged;
	logic [W-1:0] wr_st, wr_en_d;
	assign wr_merged = cmd.place;
	assign wr_en = (cmd.place || (cmd.write && valid_s1 && !touch)) && (wr_q < CW'(N));
	assign wr_st = wr_merged ? ms_q : a_s1;
	assign wr_en_d = wr_merged ? me_q : b_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (bank_q) begin
				st_mem0[wr_q[IW-1:0]] <= wr_st;
				en_mem0[wr_q[IW-1:0]] <= wr_en_d;
			end else begin
				st_mem1[wr_q[IW-1:0]] <= wr_st;
				en_mem1[wr_q[IW-1:0]] <= wr_en_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			count_q <= '0;
			idx_q <= '0;
			wr_q <= '0;
			placed_q <= 1'b0;
			merged_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
				wr_q <= '0;
				placed_q <= 1'b0;
				merged_q <= 1'b0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan_rst) idx_q <= '0;
				else if (cmd.scan && idx_q < count_q) idx_q <= idx_q + 1'b1;
				if (wr_en) wr_q <= wr_q + 1'b1;
				if (cmd.place) placed_q <= 1'b1;
				if (valid_s1 && cmd.scan && !cmd.write && touch) merged_q <= 1'b1;
				if (valid_s1 && cmd.scan && !cmd.write && hit_rev && !found_q) found_q <= 1'b1;
				if (cmd.commit) begin
					bank_q <= !bank_q;
					count_q <= wr_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_req;
			rev_q <= in_rev;
			s_q <= in_rev;
			e_q <= e_new;
			ms_q <= in_rev;
			me_q <= e_new;
			empty_q <= (in_span == '0) || (e_new <= in_rev);
			ans_q <= '0;
		end else if (valid_s1 && cmd.scan && !cmd.write) begin
			if (touch) begin
				if (a_s1 < ms_q) ms_q <= a_s1;
				if (b_s1 > me_q) me_q <= b_s1;
			end
			if (hit_rev && !found_q) begin
				ans_q <= (req_q == ism_pkg::REQ_NEXT) ? b_s1 : a_s1 - 1'b1;
			end
		end
	end

	// previous query: a range at zero reports nothing
	logic q_next, q_prev;
	assign q_next = (req_q == ism_pkg::REQ_NEXT) && found_q;
	assign q_prev = (req_q == ism_pkg::REQ_PREV) && found_q && (ans_q != ism_pkg::RevMax);
	assign res_found = q_next || q_prev;
	assign res_ans = res_found ? ans_q : '0;
	// a committed add has placed its range, so the new count does not count here
	assign res_drop = (req_q == ism_pkg::REQ_ADD) && !empty_q && !merged_q && !placed_q
		&& (count_q == CW'(N));
endmodule
`default_nettype wire

### src/ism_ctrl.sv
// Controller: sequences scan, compaction and result delivery.
// Depends on ism_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ism_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	output ism_pkg::cmd_t cmd,
	input  wire ism_pkg::sts_t sts,
	output logic busy
);
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_COMP  = 5'b00100,
		S_LAST  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;
	state_t state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					if (sts.is_add && !sts.empty_add && !sts.full_drop) begin
						cmd.scan = 1'b0;
						cmd.scan_rst = 1'b1;
						state_d = S_COMP;
					end else begin
						state_d = S_OUT;
					end
				end
			end
			S_COMP: begin
				cmd.scan = 1'b1;
				if (sts.need_place) begin
					// merged range goes first; hold the current entry meanwhile
					cmd.place = 1'b1;
					cmd.scan = 1'b0;
				end else begin
					cmd.write = 1'b1;
				end
				if (sts.scan_done && !sts.need_place) state_d = S_LAST;
				if (sts.scan_done && sts.need_place) state_d = S_LAST;
			end
			S_LAST: begin
				cmd.commit = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
	assign busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

### src/interval_set_merge_query.sv
// Top level of the interval set merge/query block.
// Depends on ism_pkg, ism_if, ism_ctrl and ism_dp.
//
// Use: requests arrive on the req channel (req_type, rev, span), one result
// per request leaves on the res channel (answer_rev, found, dropped). Both
// are valid/ready; one transfer happens when valid and ready are high.
// Add (0) merges [rev, rev+span) with every touching stored range; find
// next (1) returns the end of the range holding rev; find previous (2)
// returns its start minus one. The table is kept as start/end pairs in two
// banks of MaxRanges entries; an add that changes the table compacts the
// live bank into the other. A query, an empty add or a dropped add scans
// the live bank through the single read port, one entry per cycle.
// An add that changes the table scans twice, compacting on the second pass;
// the scan is held while the merged range is placed ahead of a kept entry.
// One request is in flight at a time; req ready is high only when the block
// is idle: the next request can enter the cycle after the result transfer.
// Reset clears the entry count, so the table is empty; entry memories are
// not cleared, and what lies beyond the count is never used.
// When the receiver stalls, the result is held and no request is taken.
`timescale 1ns / 1ps
`default_nettype none
module interval_set_merge_query (
	input  wire logic clk,
	input  wire logic arst_n,
	ism_if.sink req,
	ism_if.source res
);
	ism_pkg::cmd_t cmd;
	ism_pkg::sts_t sts;
	logic busy;

	ism_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.cmd, .sts, .busy
	);

	ism_dp u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_req(req.data.req_type), .in_rev(req.data.rev), .in_span(req.data.span),
		.res_ans(res.data.answer_rev), .res_found(res.data.found),
		.res_drop(res.data.dropped)
	);

	// no request accepted while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && res.valid)) else $error("req ready while result pending");
	// a result never reports both found and dropped
	a_fd: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.data.found && res.data.dropped))
		else $error("found and dropped together");
	// accepted request makes the block busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> busy) else $error("not busy after request");
endmodule
`default_nettype wire
